[sv/spq_pkg.sv]
// Shared constants, entry layout and operation codes for the stable priority queue.
// Used by the channel interfaces, the entry store, the summary tracker and the top level.
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int DATA_BITS     = 8;
  localparam int PRIORITY_BITS = 8;
  localparam int IDX_BITS      = $clog2(CAPACITY);
  localparam int CNT_BITS      = $clog2(CAPACITY + 1);
  localparam int KIND_BITS     = 2;
  localparam int STATUS_BITS   = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_CLR = 2'd2
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [DATA_BITS-1:0]     data;
  } entry_t;

  // Control from the sequencer to the summary tracker.
  typedef struct packed {
    logic                push;
    logic                push_first;
    logic [IDX_BITS-1:0] push_idx;
    logic                scan_valid;
    logic [IDX_BITS-1:0] scan_idx;
  } sum_ctl_t;

endpackage

[sv/spq_if.sv]
// Valid/ready channel interfaces for request and result words.
// Depends on spq_pkg for field widths.
interface spq_in_if;
  logic                              valid;
  logic                              ready;
  logic [spq_pkg::KIND_BITS-1:0]     kind;
  logic [spq_pkg::DATA_BITS-1:0]     item_data;
  logic [spq_pkg::PRIORITY_BITS-1:0] item_priority;

  modport source (output valid, output kind, output item_data, output item_priority,
                  input ready);
  modport sink (input valid, input kind, input item_data, input item_priority,
                output ready);
endinterface

interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic [spq_pkg::STATUS_BITS-1:0]   status;
  logic [spq_pkg::DATA_BITS-1:0]     removed_data;
  logic [spq_pkg::PRIORITY_BITS-1:0] removed_priority;
  logic [spq_pkg::CNT_BITS-1:0]      entry_count;
  logic [spq_pkg::DATA_BITS-1:0]     oldest_data;
  logic [spq_pkg::DATA_BITS-1:0]     best_data;
  logic [spq_pkg::PRIORITY_BITS-1:0] best_priority;

  modport source (output valid, output status, output removed_data, output removed_priority,
                  output entry_count, output oldest_data, output best_data,
                  output best_priority, input ready);
  modport sink (input valid, input status, input removed_data, input removed_priority,
                input entry_count, input oldest_data, input best_data, input best_priority,
                output ready);
endinterface

[sv/stable_priority_queue.sv]
// Stable priority queue: request channel req, result channel rsp, both valid/ready.
// Every request word (enqueue, dequeue, clear) yields exactly one result word.
// Entries sit in arrival order in a single-port-read memory; the best entry (largest
// priority, earliest on ties) and the oldest entry are kept in a summary register.
// Enqueue appends at the tail and updates the summary; its result then passes through S_FINISH.
// Enqueue on a full queue drops the item with status full; dequeue on an empty
// queue reports status empty; both leave the queue unchanged, as does clear's
// sibling, an unused kind code.
// Dequeue removes the cached best entry, then shifts the later entries down one
// place (one memory read and write per entry) and rescans the store to rebuild
// the summary (one read per entry).
// One request is in work at a time; req.ready is high while the sequencer is idle,
// also while a finished result still waits in the output register.
// When rsp stalls, the next result holds inside until the output register frees.
// Synchronous reset empties the queue and drops any pending result; the memory
// contents are not cleared, as entries beyond the count are never read.
module stable_priority_queue (
  input logic      clk,
  input logic      rst,
  spq_in_if.sink   req,
  spq_out_if.source rsp
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_RESCAN,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [CNT_BITS-1:0]      cnt;
  logic [CNT_BITS-1:0]      rd_ptr;
  logic                     pipe_v;
  logic [CNT_BITS-1:0]      pipe_idx;
  status_t                  status_q;
  entry_t                   removed;

  logic                     out_valid;
  status_t                  out_status;
  entry_t                   out_removed;
  logic [CNT_BITS-1:0]      out_count;
  logic [DATA_BITS-1:0]     out_oldest;
  entry_t                   out_best;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     issue;
  logic                     pass_done;
  logic [CNT_BITS-1:0]      shift_dst;
  entry_t                   push_word;
  entry_t                   rd_word;
  logic                     wr_en;
  logic [IDX_BITS-1:0]      wr_addr;
  entry_t                   wr_word;
  sum_ctl_t                 sum_ctl;
  logic [IDX_BITS-1:0]      best_idx;
  entry_t                   best;
  logic [DATA_BITS-1:0]     oldest;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (cnt == CNT_BITS'(CAPACITY));
  assign empty     = (cnt == '0);
  assign issue     = (state == S_SHIFT || state == S_RESCAN) && (rd_ptr < cnt);
  assign pass_done = !issue && !pipe_v;
  assign shift_dst = pipe_idx - CNT_BITS'(1);

  assign push_word.prio = req.item_priority;
  assign push_word.data = req.item_data;

  always_comb begin
    sum_ctl.push       = accept && (kind_t'(req.kind) == KIND_ENQ) && !full;
    sum_ctl.push_first = empty;
    sum_ctl.push_idx   = cnt[IDX_BITS-1:0];
    sum_ctl.scan_valid = pipe_v && (state == S_RESCAN);
    sum_ctl.scan_idx   = pipe_idx[IDX_BITS-1:0];
  end

  // Append on enqueue; during the shift pass write each word one place lower.
  assign wr_en   = sum_ctl.push || (pipe_v && state == S_SHIFT);
  assign wr_addr = sum_ctl.push ? cnt[IDX_BITS-1:0] : shift_dst[IDX_BITS-1:0];
  assign wr_word = sum_ctl.push ? push_word : rd_word;

  spq_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_word (wr_word),
    .rd_addr (rd_ptr[IDX_BITS-1:0]),
    .rd_word (rd_word)
  );

  spq_summary u_summary (
    .clk       (clk),
    .ctl       (sum_ctl),
    .push_word (push_word),
    .scan_word (rd_word),
    .best_idx  (best_idx),
    .best      (best),
    .oldest    (oldest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pipe_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pipe_v   <= issue;
      pipe_idx <= rd_ptr;
      if (issue) begin
        rd_ptr <= rd_ptr + CNT_BITS'(1);
      end
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (kind_t'(req.kind))
              KIND_ENQ: begin
                removed <= '0;
                state   <= S_FINISH;
                if (full) begin
                  status_q <= STAT_FULL;
                end else begin
                  status_q <= STAT_OK;
                  cnt      <= cnt + CNT_BITS'(1);
                end
              end
              KIND_DEQ: begin
                if (empty) begin
                  removed  <= '0;
                  status_q <= STAT_EMPTY;
                  state    <= S_FINISH;
                end else begin
                  removed  <= best;
                  status_q <= STAT_OK;
                  rd_ptr   <= CNT_BITS'(best_idx) + CNT_BITS'(1);
                  state    <= S_SHIFT;
                end
              end
              KIND_CLR: begin
                removed  <= '0;
                status_q <= STAT_OK;
                state    <= S_FINISH;
                cnt      <= '0;
              end
              default: begin
                removed  <= '0;
                status_q <= STAT_OK;
                state    <= S_FINISH;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (pass_done) begin
            cnt    <= cnt - CNT_BITS'(1);
            rd_ptr <= '0;
            state  <= S_RESCAN;
          end
        end
        S_RESCAN: begin
          if (pass_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_status  <= status_q;
            out_removed <= removed;
            out_count   <= cnt;
            out_oldest  <= empty ? '0 : oldest;
            out_best    <= empty ? '0 : best;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.removed_data     = out_removed.data;
  assign rsp.removed_priority = out_removed.prio;
  assign rsp.entry_count      = out_count;
  assign rsp.oldest_data      = out_oldest;
  assign rsp.best_data        = out_best.data;
  assign rsp.best_priority    = out_best.prio;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pipe_v) |-> (pipe_idx != '0 && pipe_idx < cnt))
    else $error("shift write outside held entries");

  a_deq_starts_shift: assert property (@(posedge clk) disable iff (rst)
    (accept && kind_t'(req.kind) == KIND_DEQ && !empty) |=> (state == S_SHIFT))
    else $error("dequeue did not start the shift pass");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == STAT_FULL) |-> (out_count == CNT_BITS'(CAPACITY)))
    else $error("full status with room left");

  a_empty_summary: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count == '0) |-> (out_best == '0 && out_oldest == '0))
    else $error("summary fields nonzero on empty queue");

endmodule

[sv/spq_store.sv]
// Entry store: one write port and one read port with registered read data.
// Depends on spq_pkg for the entry layout and depth.
module spq_store (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [spq_pkg::IDX_BITS-1:0] wr_addr,
  input  spq_pkg::entry_t          wr_word,
  input  logic [spq_pkg::IDX_BITS-1:0] rd_addr,
  output spq_pkg::entry_t          rd_word
);
  import spq_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word <= mem[rd_addr];
  end

endmodule

[sv/spq_summary.sv]
// Tracks the oldest entry and the earliest highest-priority entry and its index.
// Updated on appends and rebuilt by a scan over the store. Depends on spq_pkg.
module spq_summary (
  input  logic                     clk,
  input  spq_pkg::sum_ctl_t        ctl,
  input  spq_pkg::entry_t          push_word,
  input  spq_pkg::entry_t          scan_word,
  output logic [spq_pkg::IDX_BITS-1:0] best_idx,
  output spq_pkg::entry_t          best,
  output logic [spq_pkg::DATA_BITS-1:0] oldest
);
  import spq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      // strictly greater keeps the earlier entry on ties
      if (ctl.push_first || push_word.prio > best.prio) begin
        best     <= push_word;
        best_idx <= ctl.push_idx;
      end
      if (ctl.push_first) begin
        oldest <= push_word.data;
      end
    end else if (ctl.scan_valid) begin
      if (ctl.scan_idx == '0) begin
        best     <= scan_word;
        best_idx <= '0;
        oldest   <= scan_word.data;
      end else if (scan_word.prio > best.prio) begin
        best     <= scan_word;
        best_idx <= ctl.scan_idx;
      end
    end
  end

endmodule
